/* rtl/core/gdee_pkg.sv */
package gdee_pkg;

    // Command codes carried on the opcode field.
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_ADD   = 2'd2;
    localparam logic [1:0] OP_EPOCH = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_YEAR_MIN = 1'b0;
    localparam logic CFG_YEAR_MAX = 1'b1;

    localparam logic [11:0] EPOCH_YEAR   = 12'd1970;
    localparam logic [11:0] YEAR_MIN_RST = 12'd1970;
    localparam logic [11:0] YEAR_MAX_RST = 12'd2099;
    localparam logic [3:0]  LAST_MONTH   = 4'd12;

    // Residues of 1970 used to seed the leap-year counters.
    localparam logic [1:0] EPOCH_MOD4   = 2'd2;
    localparam logic [6:0] EPOCH_MOD100 = 7'd70;
    localparam logic [8:0] EPOCH_MOD400 = 9'd370;
    localparam logic [6:0] MOD100_LAST  = 7'd99;
    localparam logic [8:0] MOD400_LAST  = 9'd399;

    // 1970-01-01 was a Thursday (Monday is 0).
    localparam logic [2:0] EPOCH_WEEKDAY = 3'd3;

    // Day count of 4096-01-01; every valid date lies below it.
    localparam logic [20:0] DAY_LIMIT = 21'd776506;

    // Sequencer condition selects.
    localparam logic [2:0] C_NEVER  = 3'd0;
    localparam logic [2:0] C_YEQ    = 3'd1;
    localparam logic [2:0] C_DAYBAD = 3'd2;
    localparam logic [2:0] C_ADDOVF = 3'd3;
    localparam logic [2:0] C_ISADD  = 3'd4;
    localparam logic [2:0] C_REMLTY = 3'd5;
    localparam logic [2:0] C_MSTOP  = 3'd6;

    // Datapath actions.
    localparam logic [3:0] A_NOP    = 4'd0;
    localparam logic [3:0] A_CINIT  = 4'd1;
    localparam logic [3:0] A_CYEAR  = 4'd2;
    localparam logic [3:0] A_REJECT = 4'd3;
    localparam logic [3:0] A_MINIT  = 4'd4;
    localparam logic [3:0] A_CMONTH = 4'd5;
    localparam logic [3:0] A_CDAY   = 4'd6;
    localparam logic [3:0] A_FAIL   = 4'd7;
    localparam logic [3:0] A_LDSUM  = 4'd8;
    localparam logic [3:0] A_COMMIT = 4'd9;
    localparam logic [3:0] A_FINIT  = 4'd10;
    localparam logic [3:0] A_FYEAR  = 4'd11;
    localparam logic [3:0] A_FDAY   = 4'd12;
    localparam logic [3:0] A_FMONTH = 4'd13;
    localparam logic [3:0] A_DONE   = 4'd14;

    // Program step addresses.
    localparam logic [3:0] S_CINIT  = 4'd0;
    localparam logic [3:0] S_CY     = 4'd1;
    localparam logic [3:0] S_CCHK   = 4'd2;
    localparam logic [3:0] S_CMINIT = 4'd3;
    localparam logic [3:0] S_CM     = 4'd4;
    localparam logic [3:0] S_CD     = 4'd5;
    localparam logic [3:0] S_OVF    = 4'd6;
    localparam logic [3:0] S_DISP   = 4'd7;
    localparam logic [3:0] S_FINIT  = 4'd8;
    localparam logic [3:0] S_FY     = 4'd9;
    localparam logic [3:0] S_FMINIT = 4'd10;
    localparam logic [3:0] S_FM     = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    // One control word: when the condition holds the true action and jump
    // are taken, otherwise the false ones.
    typedef struct packed {
        logic [2:0] cond;
        logic [3:0] act_t;
        logic [3:0] tgt_t;
        logic [3:0] act_f;
        logic [3:0] tgt_f;
    } t_uword;

    function automatic t_uword f_ucode(input logic [3:0] pc);
        t_uword w;
        unique case (pc)
            S_CINIT:  w = '{C_NEVER,  A_NOP,    S_CINIT,  A_CINIT,  S_CY};
            S_CY:     w = '{C_YEQ,    A_NOP,    S_CCHK,   A_CYEAR,  S_CY};
            S_CCHK:   w = '{C_DAYBAD, A_REJECT, S_CINIT,  A_NOP,    S_CMINIT};
            S_CMINIT: w = '{C_NEVER,  A_NOP,    S_CINIT,  A_MINIT,  S_CM};
            // The month walk toward a target date stops on a month match.
            S_CM:     w = '{C_YEQ,    A_NOP,    S_CD,     A_CMONTH, S_CM};
            S_CD:     w = '{C_NEVER,  A_NOP,    S_CINIT,  A_CDAY,   S_OVF};
            S_OVF:    w = '{C_ADDOVF, A_FAIL,   S_DONE,   A_NOP,    S_DISP};
            S_DISP:   w = '{C_ISADD,  A_LDSUM,  S_FINIT,  A_COMMIT, S_DONE};
            S_FINIT:  w = '{C_NEVER,  A_NOP,    S_CINIT,  A_FINIT,  S_FY};
            S_FY:     w = '{C_REMLTY, A_NOP,    S_FMINIT, A_FYEAR,  S_FY};
            S_FMINIT: w = '{C_NEVER,  A_NOP,    S_CINIT,  A_MINIT,  S_FM};
            S_FM:     w = '{C_MSTOP,  A_FDAY,   S_DONE,   A_FMONTH, S_FM};
            default:  w = '{C_NEVER,  A_NOP,    S_CINIT,  A_DONE,   S_CINIT};
        endcase
        return w;
    endfunction

    function automatic logic [4:0] f_mlen(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // Weekday advanced by a delta of at most 31 days, modulo 7.
    function automatic logic [2:0] f_wd_add(input logic [2:0] wd, input logic [4:0] delta);
        logic [5:0] s;
        logic [5:0] r;
        s = {3'b000, wd} + {1'b0, delta};
        priority if (s >= 6'd35) begin
            r = s - 6'd35;
        end else if (s >= 6'd28) begin
            r = s - 6'd28;
        end else if (s >= 6'd21) begin
            r = s - 6'd21;
        end else if (s >= 6'd14) begin
            r = s - 6'd14;
        end else if (s >= 6'd7) begin
            r = s - 6'd7;
        end else begin
            r = s;
        end
        return r[2:0];
    endfunction

endpackage

/* rtl/core/gregorian_date_epoch_engine.sv */
// Gregorian date engine. It holds one calendar date and runs one command
// word at a time: read, set date, add days, or set from a day count since
// 1970-01-01. A command word is taken at a rising edge where start is high
// and busy is low; busy then stays high until the result word is out.
// Each command returns one result word, shown for exactly one cycle with
// o_done high: the ok flag, the date held afterwards, its day count since
// 1970-01-01 and its weekday (0 Monday). The receiver cannot stall.
// A small microprogram drives the datapath. A date-to-count conversion
// walks year by year from 1970 to the target year and then month by month.
// A count-to-date conversion walks the same way. A set whose day is past
// the end of its month walks once to find that out and once more for the
// held date; add runs both conversions. The year walk is what sets the
// latency. The year limits are written over the i_cfg port; the user must
// write them only while the block is idle, as the block does not enforce it.
// Reset loads 1970-01-01, year limits 1970 and 2099, and leaves the block
// idle with no result pending.
module gregorian_date_epoch_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [4:0]  i_day_in,
    input  logic [3:0]  i_month_in,
    input  logic [11:0] i_year_in,
    input  logic [19:0] i_day_count,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [11:0] i_cfg_data,
    output logic        o_done,
    output logic        o_ok,
    output logic [4:0]  o_day_out,
    output logic [3:0]  o_month_out,
    output logic [11:0] o_year_out,
    output logic [19:0] o_epoch_days,
    output logic [2:0]  o_weekday
);

    // Configuration.
    logic [11:0] r_year_min;
    logic [11:0] r_year_max;

    // Held date.
    logic [4:0]  r_cur_day;
    logic [3:0]  r_cur_month;
    logic [11:0] r_cur_year;

    // Sequencer.
    logic        r_busy;
    logic [3:0]  r_pc;

    // Command context.
    logic        r_ok;
    logic        r_chk;
    logic        r_is_add;
    logic [19:0] r_cnt;
    logic [4:0]  r_td;
    logic [3:0]  r_tm;
    logic [11:0] r_ty;

    // Walk datapath.
    logic [11:0] r_y;
    logic [3:0]  r_m;
    logic [1:0]  r_y4;
    logic [6:0]  r_y100;
    logic [8:0]  r_y400;
    logic [19:0] r_acc;
    logic [19:0] r_rem;
    logic [2:0]  r_wd;

    gdee_pkg::t_uword w_uw;
    logic        w_leap;
    logic [8:0]  w_ylen;
    logic [4:0]  w_ylen_wd;
    logic [4:0]  w_mlen;
    logic [20:0] w_sum;
    logic        w_cond;
    logic [3:0]  w_act;
    logic [3:0]  w_tgt;
    logic        w_accept;
    logic        w_set_ok;

    assign busy     = r_busy;
    assign w_accept = start && !r_busy;

    // Year counters track y mod 4, 100 and 400 so the leap test needs no divider.
    assign w_leap    = ((r_y4 == 2'd0) && (r_y100 != 7'd0)) || (r_y400 == 9'd0);
    assign w_ylen    = w_leap ? 9'd366 : 9'd365;
    assign w_ylen_wd = w_leap ? 5'd2 : 5'd1;
    assign w_mlen    = gdee_pkg::f_mlen(r_m, w_leap);
    assign w_sum     = {1'b0, r_acc} + {1'b0, r_cnt};

    // Checks on a set command that need no calendar walk.
    assign w_set_ok = (i_year_in >= gdee_pkg::EPOCH_YEAR) && (i_year_in >= r_year_min) &&
                      (i_year_in <= r_year_max) && (i_month_in >= 4'd1) &&
                      (i_month_in <= gdee_pkg::LAST_MONTH) && (i_day_in != 5'd0);

    always_comb begin
        w_uw = gdee_pkg::f_ucode(r_pc);
        unique case (w_uw.cond)
            gdee_pkg::C_NEVER:  w_cond = 1'b0;
            gdee_pkg::C_YEQ:    w_cond = (r_pc == gdee_pkg::S_CM) ? (r_m == r_tm)
                                                                   : (r_y == r_ty);
            gdee_pkg::C_DAYBAD: w_cond = r_chk &&
                                         (r_td > gdee_pkg::f_mlen(r_tm, w_leap));
            gdee_pkg::C_ADDOVF: w_cond = r_is_add && (w_sum >= gdee_pkg::DAY_LIMIT);
            gdee_pkg::C_ISADD:  w_cond = r_is_add;
            gdee_pkg::C_REMLTY: w_cond = (r_rem < {11'd0, w_ylen});
            gdee_pkg::C_MSTOP:  w_cond = (r_m == gdee_pkg::LAST_MONTH) ||
                                         (r_rem < {15'd0, w_mlen});
            default:            w_cond = 1'b0;
        endcase
        w_act = w_cond ? w_uw.act_t : w_uw.act_f;
        w_tgt = w_cond ? w_uw.tgt_t : w_uw.tgt_f;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year_min  <= gdee_pkg::YEAR_MIN_RST;
            r_year_max  <= gdee_pkg::YEAR_MAX_RST;
            r_cur_day   <= 5'd1;
            r_cur_month <= 4'd1;
            r_cur_year  <= gdee_pkg::EPOCH_YEAR;
            r_busy      <= 1'b0;
            r_pc        <= gdee_pkg::S_CINIT;
            o_done      <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_idx == gdee_pkg::CFG_YEAR_MIN) begin
                    r_year_min <= i_cfg_data;
                end else begin
                    r_year_max <= i_cfg_data;
                end
            end
            if (w_accept) begin
                r_busy <= 1'b1;
                // An epoch-set within range goes straight to the count-to-date walk.
                if ((i_opcode == gdee_pkg::OP_EPOCH) &&
                    ({1'b0, i_day_count} < gdee_pkg::DAY_LIMIT)) begin
                    r_pc <= gdee_pkg::S_FINIT;
                end else begin
                    r_pc <= gdee_pkg::S_CINIT;
                end
            end else if (r_busy) begin
                r_pc <= w_tgt;
                unique case (w_act)
                    gdee_pkg::A_COMMIT: begin
                        r_cur_day   <= r_td;
                        r_cur_month <= r_tm;
                        r_cur_year  <= r_ty;
                    end
                    gdee_pkg::A_FDAY: begin
                        r_cur_day   <= r_rem[4:0] + 5'd1;
                        r_cur_month <= r_m;
                        r_cur_year  <= r_y;
                    end
                    gdee_pkg::A_DONE: begin
                        r_busy <= 1'b0;
                        o_done <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath and result registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ok     <= 1'b1;
            r_chk    <= 1'b0;
            r_is_add <= (i_opcode == gdee_pkg::OP_ADD);
            r_cnt    <= i_day_count;
            r_rem    <= i_day_count;
            r_td     <= r_cur_day;
            r_tm     <= r_cur_month;
            r_ty     <= r_cur_year;
            unique case (i_opcode)
                gdee_pkg::OP_SET: begin
                    if (w_set_ok) begin
                        r_chk <= 1'b1;
                        r_td  <= i_day_in;
                        r_tm  <= i_month_in;
                        r_ty  <= i_year_in;
                    end else begin
                        r_ok <= 1'b0;
                    end
                end
                gdee_pkg::OP_EPOCH: begin
                    if ({1'b0, i_day_count} >= gdee_pkg::DAY_LIMIT) begin
                        r_ok <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end else if (r_busy) begin
            unique case (w_act)
                gdee_pkg::A_CINIT, gdee_pkg::A_FINIT: begin
                    r_y    <= gdee_pkg::EPOCH_YEAR;
                    r_y4   <= gdee_pkg::EPOCH_MOD4;
                    r_y100 <= gdee_pkg::EPOCH_MOD100;
                    r_y400 <= gdee_pkg::EPOCH_MOD400;
                    r_wd   <= gdee_pkg::EPOCH_WEEKDAY;
                    r_acc  <= (w_act == gdee_pkg::A_CINIT) ? 20'd0 : r_rem;
                end
                gdee_pkg::A_CYEAR, gdee_pkg::A_FYEAR: begin
                    if (w_act == gdee_pkg::A_CYEAR) begin
                        r_acc <= r_acc + {11'd0, w_ylen};
                    end else begin
                        r_rem <= r_rem - {11'd0, w_ylen};
                    end
                    r_wd   <= gdee_pkg::f_wd_add(r_wd, w_ylen_wd);
                    r_y    <= r_y + 12'd1;
                    r_y4   <= r_y4 + 2'd1;
                    r_y100 <= (r_y100 == gdee_pkg::MOD100_LAST) ? 7'd0 : r_y100 + 7'd1;
                    r_y400 <= (r_y400 == gdee_pkg::MOD400_LAST) ? 9'd0 : r_y400 + 9'd1;
                end
                gdee_pkg::A_REJECT: begin
                    // The day is past the end of its month: keep the old date.
                    r_ok  <= 1'b0;
                    r_chk <= 1'b0;
                    r_td  <= r_cur_day;
                    r_tm  <= r_cur_month;
                    r_ty  <= r_cur_year;
                end
                gdee_pkg::A_MINIT: begin
                    r_m <= 4'd1;
                end
                gdee_pkg::A_CMONTH, gdee_pkg::A_FMONTH: begin
                    if (w_act == gdee_pkg::A_CMONTH) begin
                        r_acc <= r_acc + {15'd0, w_mlen};
                    end else begin
                        r_rem <= r_rem - {15'd0, w_mlen};
                    end
                    r_wd <= gdee_pkg::f_wd_add(r_wd, w_mlen);
                    r_m  <= r_m + 4'd1;
                end
                gdee_pkg::A_CDAY: begin
                    r_acc <= r_acc + {15'd0, r_td - 5'd1};
                    r_wd  <= gdee_pkg::f_wd_add(r_wd, r_td - 5'd1);
                end
                gdee_pkg::A_FAIL: begin
                    r_ok <= 1'b0;
                end
                gdee_pkg::A_LDSUM: begin
                    r_rem <= w_sum[19:0];
                end
                gdee_pkg::A_FDAY: begin
                    r_wd <= gdee_pkg::f_wd_add(r_wd, r_rem[4:0]);
                end
                gdee_pkg::A_DONE: begin
                    o_ok         <= r_ok;
                    o_day_out    <= r_cur_day;
                    o_month_out  <= r_cur_month;
                    o_year_out   <= r_cur_year;
                    o_epoch_days <= r_acc;
                    o_weekday    <= r_wd;
                end
                default: begin
                end
            endcase
        end
    end

endmodule
